// ----- design/bswi_pkg.sv -----
// Shared constants, types and the key ordering function of the byte sorter.
package bswi_pkg;

    // Capacity of one set and the widths that follow from it.
    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // Fixed field widths.
    localparam int KEY_W  = 8;
    localparam int POS_W  = 7;

    // Configuration port.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_DESCENDING  = 2'd0;
    localparam logic [1:0] REG_SIGNED_KEYS = 2'd1;
    localparam logic [1:0] REG_WITH_INDEX  = 2'd2;

    // Configuration values seen by the datapath.
    typedef struct packed {
        logic descending;
        logic signed_keys;
        logic with_index;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_en;
        logic sort_en;
        logic sort_phase;
        logic shift_en;
        logic clear_set;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic head_valid;
        logic next_valid;
    } sts_t;

    // True when entry a must be placed after entry b. An empty cell goes
    // after every loaded one; equal keys are ordered by load position.
    function automatic logic comes_after(
        input logic             va,
        input logic [KEY_W-1:0] ka,
        input logic [POS_W-1:0] pa,
        input logic             vb,
        input logic [KEY_W-1:0] kb,
        input logic [POS_W-1:0] pb,
        input logic             desc,
        input logic             sgn
    );
        logic [KEY_W-1:0] ra;
        logic [KEY_W-1:0] rb;
        logic             res;
        ra = ka ^ {sgn, {(KEY_W-1){1'b0}}};
        rb = kb ^ {sgn, {(KEY_W-1){1'b0}}};
        if (desc)
        begin
            ra = ~ra;
            rb = ~rb;
        end
        if (!vb)
        begin
            res = 1'b0;
        end
        else if (!va)
        begin
            res = 1'b1;
        end
        else if (ra != rb)
        begin
            res = (ra > rb);
        end
        else
        begin
            res = (pa > pb);
        end
        return res;
    endfunction

endpackage

// ----- design/byte_sort_with_index_top.sv -----
// Top level of the byte sorter: configuration registers and block wiring.
//
// The block takes a set of up to 64 byte keys, one key transfer per cycle,
// and after the transfer marked last_key returns the keys in sorted order,
// one result transfer per stored key, each with its 1-based load position
// (or zero when with_index is clear). A set of n keys is loaded, then an
// odd-even exchange network over the row of 64 key cells orders the set,
// then the n results are drained; input is stalled from the final key
// until the last result has been taken. Keys that arrive when 64 are
// stored are dropped and every result of that set shows overflow.
// Configuration is written through the APB port at byte addresses 0
// (descending), 4 (signed_keys) and 8 (with_index) between sets.
module byte_sort_with_index_top
    import bswi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [KEY_W-1:0]  key_byte,
    input  logic              last_key,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [KEY_W-1:0]  sorted_key,
    output logic [POS_W-1:0]  origin_index,
    output logic              last_out,
    output logic              overflow
);

    cfg_t cfg_reg;
    logic cfg_write;
    cmd_t cmd;
    sts_t sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.descending  <= 1'b0;
            cfg_reg.signed_keys <= 1'b0;
            cfg_reg.with_index  <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_DESCENDING:  cfg_reg.descending  <= pwdata[0];
                REG_SIGNED_KEYS: cfg_reg.signed_keys <= pwdata[0];
                REG_WITH_INDEX:  cfg_reg.with_index  <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Configuration register reads.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_DESCENDING:  prdata = DATA_W'(cfg_reg.descending);
            REG_SIGNED_KEYS: prdata = DATA_W'(cfg_reg.signed_keys);
            REG_WITH_INDEX:  prdata = DATA_W'(cfg_reg.with_index);
            default:         prdata = '0;
        endcase
    end

    // Sequencing of load, sort and drain.
    bswi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_key  (last_key),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // Key cells and ordering network.
    bswi_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg_reg),
        .key_byte     (key_byte),
        .sts          (sts),
        .sorted_key   (sorted_key),
        .origin_index (origin_index),
        .last_out     (last_out),
        .overflow     (overflow)
    );

endmodule

// ----- design/bswi_ctrl.sv -----
// Controller of the byte sorter: load, sort and drain sequencing.
module bswi_ctrl
    import bswi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic last_key,
    input  logic out_stall,
    input  sts_t sts,
    output logic in_stall,
    output logic out_valid,
    output cmd_t cmd
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_SORT  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] round_reg;
    logic [IDX_W-1:0] round_next;
    logic             load_xfer;
    logic             out_xfer;

    // Handshake decode.
    always_comb
    begin
        in_stall  = (state_reg != ST_LOAD);
        load_xfer = in_valid && !in_stall;
        out_valid = (state_reg == ST_DRAIN) && sts.head_valid;
        out_xfer  = out_valid && !out_stall;
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd.load_en    = load_xfer;
        cmd.sort_en    = (state_reg == ST_SORT);
        cmd.sort_phase = round_reg[0];
        cmd.shift_en   = out_xfer;
        cmd.clear_set  = out_xfer && !sts.next_valid;
    end

    // Next state and sort round.
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                round_next = '0;
                if (load_xfer && last_key)
                begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT:
            begin
                round_next = round_reg + IDX_W'(1);
                if (round_reg == IDX_W'(MAX_ITEMS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (cmd.clear_set)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            round_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
        end
    end

    // The final result transfer reopens the input at the next edge.
    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && !sts.next_valid) |=> (!in_stall && !out_valid))
        else $error("input not reopened after final result");

endmodule

// ----- design/bswi_datapath.sv -----
// Datapath of the byte sorter: a row of key cells with odd-even exchange.
module bswi_datapath
    import bswi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  cfg_t             cfg,
    input  logic [KEY_W-1:0] key_byte,
    output sts_t             sts,
    output logic [KEY_W-1:0] sorted_key,
    output logic [POS_W-1:0] origin_index,
    output logic             last_out,
    output logic             overflow
);

    logic [KEY_W-1:0]     key_reg [MAX_ITEMS];
    logic [KEY_W-1:0]     key_next [MAX_ITEMS];
    logic [POS_W-1:0]     pos_reg [MAX_ITEMS];
    logic [POS_W-1:0]     pos_next [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] vld_reg;
    logic [MAX_ITEMS-1:0] vld_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 ovf_reg;
    logic                 ovf_next;
    logic                 full;

    assign full = (count_reg == CNT_W'(MAX_ITEMS));

    // Cell row update: load at the fill point, exchange pairs, or shift out.
    always_comb
    begin
        key_next = key_reg;
        pos_next = pos_reg;
        vld_next = vld_reg;
        if (cmd.load_en && !full)
        begin
            key_next[count_reg[IDX_W-1:0]] = key_byte;
            pos_next[count_reg[IDX_W-1:0]] = POS_W'(count_reg) + POS_W'(1);
            vld_next[count_reg[IDX_W-1:0]] = 1'b1;
        end
        else if (cmd.sort_en)
        begin
            for (int i = 0; i < MAX_ITEMS - 1; i++)
            begin
                if ((i[0] == cmd.sort_phase) &&
                    comes_after(vld_reg[i], key_reg[i], pos_reg[i],
                                vld_reg[i+1], key_reg[i+1], pos_reg[i+1],
                                cfg.descending, cfg.signed_keys))
                begin
                    key_next[i]   = key_reg[i+1];
                    key_next[i+1] = key_reg[i];
                    pos_next[i]   = pos_reg[i+1];
                    pos_next[i+1] = pos_reg[i];
                    vld_next[i]   = vld_reg[i+1];
                    vld_next[i+1] = vld_reg[i];
                end
            end
        end
        else if (cmd.shift_en)
        begin
            for (int i = 0; i < MAX_ITEMS - 1; i++)
            begin
                key_next[i] = key_reg[i+1];
                pos_next[i] = pos_reg[i+1];
            end
            vld_next = {1'b0, vld_reg[MAX_ITEMS-1:1]};
        end
    end

    // Fill count and overflow flag of the current set.
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.clear_set)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (cmd.load_en)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    // Key and position cells carry no reset.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pos_reg <= pos_next;
    end

    // Control state of the cell row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            vld_reg   <= vld_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // The head cell is the result presented to the output.
    always_comb
    begin
        sts.head_valid = vld_reg[0];
        sts.next_valid = vld_reg[1];
        sorted_key     = key_reg[0];
        origin_index   = cfg.with_index ? pos_reg[0] : '0;
        last_out       = !vld_reg[1];
        overflow       = ovf_reg;
    end

    // The fill count never passes the capacity.
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("fill count beyond capacity");

    // Loaded cells always form one block starting at cell zero.
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg & (vld_reg + MAX_ITEMS'(1))) == '0)
        else $error("loaded cells not contiguous");

    // Shifting out the final cell leaves the row empty.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shift_en && !vld_reg[1]) |=> (vld_reg == '0))
        else $error("cells remain after final result");

endmodule

// ----- sim/byte_sort_with_index_checker.sv -----
`timescale 1ns / 1ps
// Checker for the byte sorter: follows each key set, predicts its sorted run and compares results.
module byte_sort_with_index_checker
    import bswi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [KEY_W-1:0]  key_byte,
    input  logic              last_key,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [KEY_W-1:0]  sorted_key,
    input  logic [POS_W-1:0]  origin_index,
    input  logic              last_out,
    input  logic              overflow,
    output int                fail_count,
    output int                results_due
);

    // One predicted result transfer.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] index;
        logic             last;
        logic             ovf;
    } sorted_entry_t;

    localparam int               REPORT_LIMIT = 10;
    localparam logic [KEY_W-1:0] SIGN_FLIP    = 8'h80;

    // Register copy and the keys of the set being loaded.
    cfg_t              cfg;
    logic [KEY_W-1:0]  set_keys [MAX_ITEMS];
    logic [POS_W-1:0]  set_pos  [MAX_ITEMS];
    int                set_count;
    logic              set_dropped;
    sorted_entry_t     sorted_q [$];

    // Rank of a key under the current ordering; lower ranks leave first.
    function automatic logic [KEY_W-1:0] order_rank(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        r = cfg.signed_keys ? (k ^ SIGN_FLIP) : k;
        if (cfg.descending)
            r = ~r;
        return r;
    endfunction

    // True when stored entry a belongs after stored entry b.
    function automatic logic goes_after(input int a, input int b);
        logic [KEY_W-1:0] ra;
        logic [KEY_W-1:0] rb;
        ra = order_rank(set_keys[a]);
        rb = order_rank(set_keys[b]);
        if (ra != rb)
            return ra > rb;
        return set_pos[a] > set_pos[b];
    endfunction

    // Stable insertion sort of the stored set, queued as expected results.
    task automatic predict_sorted_run();
        int            order [MAX_ITEMS];
        int            k;
        sorted_entry_t e;
        for (int i = 0; i < set_count; i++)
        begin
            k = i;
            while (k > 0 && goes_after(order[k-1], i))
            begin
                order[k] = order[k-1];
                k--;
            end
            order[k] = i;
        end
        for (int j = 0; j < set_count; j++)
        begin
            e.key   = set_keys[order[j]];
            e.index = cfg.with_index ? set_pos[order[j]] : '0;
            e.last  = (j == set_count - 1);
            e.ovf   = set_dropped;
            sorted_q.push_back(e);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sorted_entry_t exp;
        if (!rst_n)
        begin
            cfg         = '{descending: 1'b0, signed_keys: 1'b0, with_index: 1'b1};
            set_count   = 0;
            set_dropped = 1'b0;
            sorted_q.delete();
            fail_count  = 0;
            results_due = 0;
        end
        else
        begin
            // Register writes update the local copy.
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_DESCENDING:  cfg.descending  = pwdata[0];
                    REG_SIGNED_KEYS: cfg.signed_keys = pwdata[0];
                    REG_WITH_INDEX:  cfg.with_index  = pwdata[0];
                    default: ;
                endcase
            end

            // Each result transfer is checked against the oldest prediction.
            if (out_valid && !out_stall)
            begin
                if (sorted_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result key %02h index %0d last %0b ovf %0b",
                                 $realtime, sorted_key, origin_index, last_out, overflow);
                end
                else
                begin
                    exp = sorted_q.pop_front();
                    if (sorted_key !== exp.key || origin_index !== exp.index ||
                        last_out !== exp.last || overflow !== exp.ovf)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%0t: expected key %02h index %0d last %0b ovf %0b, %s",
                                     $realtime, exp.key, exp.index, exp.last, exp.ovf,
                                     $sformatf("got key %02h index %0d last %0b ovf %0b",
                                               sorted_key, origin_index, last_out,
                                               overflow));
                    end
                end
            end

            // Key transfers build the set; the final key releases the sorted run.
            if (in_valid && !in_stall)
            begin
                if (set_count < MAX_ITEMS)
                begin
                    set_keys[set_count] = key_byte;
                    set_pos[set_count]  = POS_W'(set_count + 1);
                    set_count++;
                end
                else
                    set_dropped = 1'b1;
                if (last_key)
                begin
                    predict_sorted_run();
                    set_count   = 0;
                    set_dropped = 1'b0;
                end
            end

            results_due = sorted_q.size();
        end
    end

endmodule

// ----- sim/byte_sort_with_index_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the byte sorter: clock, reset, key and register stimulus, and the verdict.
module byte_sort_with_index_top_tb;
    import bswi_pkg::*;

    typedef logic [KEY_W-1:0] key_list_t [$];

    localparam int SETTLE_CYCLES = 100;
    localparam int DRAIN_CYCLES  = 100;
    localparam int IDLE_LIMIT    = 5000;
    localparam int HOLD_STRETCH  = 300;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic [KEY_W-1:0]  key_byte;
    logic              last_key;
    logic              out_valid;
    logic              out_stall;
    logic [KEY_W-1:0]  sorted_key;
    logic [POS_W-1:0]  origin_index;
    logic              last_out;
    logic              overflow;

    int fail_count;
    int results_due;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int keys_sent;

    byte_sort_with_index_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .key_byte     (key_byte),
        .last_key     (last_key),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_key   (sorted_key),
        .origin_index (origin_index),
        .last_out     (last_out),
        .overflow     (overflow)
    );

    byte_sort_with_index_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .key_byte     (key_byte),
        .last_key     (last_key),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_key   (sorted_key),
        .origin_index (origin_index),
        .last_out     (last_out),
        .overflow     (overflow),
        .fail_count   (fail_count),
        .results_due  (results_due)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offer one key; the transfer completes at the first rising edge without stall.
    task automatic send_key(input logic [KEY_W-1:0] k, input logic is_last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        key_byte = k;
        last_key = is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        keys_sent++;
        @(negedge clk);
    endtask

    // Send a whole set with the final key marked.
    task automatic send_set(input key_list_t keys);
        foreach (keys[i])
            send_key(keys[i], i == keys.size() - 1);
        in_valid = 1'b0;
        last_key = 1'b0;
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [1:0] reg_sel, input logic value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {reg_sel, 2'b00};
        pwdata  = DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // New settings go in only once the block has drained and settled.
    task automatic set_config(input logic desc, input logic sgn, input logic widx);
        while (results_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(REG_DESCENDING, desc);
        write_reg(REG_SIGNED_KEYS, sgn);
        write_reg(REG_WITH_INDEX, widx);
    endtask

    // Random set: uniform bytes, values from a pool of three, or mostly the byte extremes.
    function automatic key_list_t random_set(input int n);
        key_list_t        keys;
        logic [KEY_W-1:0] pool [3];
        int               style;
        style = $urandom_range(2);
        foreach (pool[i])
            pool[i] = KEY_W'($urandom);
        for (int i = 0; i < n; i++)
        begin
            case (style)
                0: keys.push_back(KEY_W'($urandom));
                1: keys.push_back(pool[$urandom_range(2)]);
                default:
                    case ($urandom_range(4))
                        0: keys.push_back(8'h00);
                        1: keys.push_back(8'h7F);
                        2: keys.push_back(8'h80);
                        3: keys.push_back(8'hFF);
                        default: keys.push_back(KEY_W'($urandom));
                    endcase
            endcase
        end
        return keys;
    endfunction

    // Small random sets, with an occasional change of settings between them.
    task automatic run_small_sets(input int key_target);
        while (keys_sent < key_target)
        begin
            if ($urandom_range(3) == 0)
                set_config(1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
            send_set(random_set($urandom_range(1, 10)));
        end
    endtask

    // Result side: random stall, or a long counted hold-off when requested.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall = 1'b1;
                hold_cycles--;
            end
            else
                out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Main stimulus.
    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        key_byte      = '0;
        last_key      = 1'b0;
        send_idle_pct = 23;
        recv_idle_pct = 84;
        hold_cycles   = 0;
        keys_sent     = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed sets under the reset settings: a lone key, then the byte extremes.
        send_set('{8'h80});
        send_set('{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h01, 8'hFE});
        // Descending signed order with indices off.
        set_config(1'b1, 1'b1, 1'b0);
        send_set('{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h01, 8'hFE});
        // Repeated keys must keep their load order.
        set_config(1'b0, 1'b1, 1'b1);
        send_set('{8'h05, 8'h05, 8'h80, 8'h05, 8'h80, 8'hFF});
        set_config(1'b1, 1'b0, 1'b1);
        send_set('{8'h42, 8'h42, 8'h00, 8'hFF, 8'h42});
        run_small_sets(45);

        // Slow sender, mostly ready receiver; one full-capacity set.
        send_idle_pct = 84;
        recv_idle_pct = 23;
        set_config(1'b1, 1'b1, 1'b1);
        send_set(random_set(MAX_ITEMS));
        run_small_sets(125);

        // No idling; a long hold-off on the results while the next set waits.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(1'b0, 1'b0, 1'b0);
        hold_cycles = HOLD_STRETCH;
        send_set(random_set(12));
        send_set(random_set(8));
        // Keys past capacity are dropped, the last of them carrying the end mark.
        set_config(1'b0, 1'b1, 1'b1);
        send_set(random_set(MAX_ITEMS + 2));
        run_small_sets(215);

        // Drain and give the verdict.
        while (results_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && results_due == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
